// ----- design/esd_pkg.sv -----
// Shared types, character codes and helper functions for the escape sequence decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package esd_pkg;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [11:0] BYTE_MAX_VALUE = 12'd255;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_V   = 8'h76;
    localparam logic [7:0] CH_LC_X   = 8'h78;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_F   = 8'h46;
    localparam logic [7:0] CH_UC_X   = 8'h58;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [7:0] CODE_BEL = 8'd7;
    localparam logic [7:0] CODE_BS  = 8'd8;
    localparam logic [7:0] CODE_HT  = 8'd9;
    localparam logic [7:0] CODE_LF  = 8'd10;
    localparam logic [7:0] CODE_VT  = 8'd11;
    localparam logic [7:0] CODE_FF  = 8'd12;
    localparam logic [7:0] CODE_CR  = 8'd13;

    typedef enum logic [2:0] {
        PH_PLAIN = 3'd0,
        PH_ESC   = 3'd1,
        PH_HEX   = 3'd2,
        PH_OCT   = 3'd3,
        PH_DEC   = 3'd4
    } t_phase;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       bad_escape;
        logic       run_last;
        logic       string_done;
    } t_result;

    typedef struct packed {
        logic [1:0] num;
        t_result    res_a;
        t_result    res_b;
    } t_push;

    function automatic t_result mk_result(input logic [7:0] value, input logic bad);
        t_result r;
        r.byte_out    = bad ? 8'd0 : value;
        r.bad_escape  = bad;
        r.run_last    = 1'b0;
        r.string_done = 1'b0;
        return r;
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= CH_LC_A && c <= CH_LC_F) || (c >= CH_UC_A && c <= CH_UC_F)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/esd_decoder.sv -----
// Input register, parse state and single-pass escape decode for one character.
// Depends on esd_pkg; feeds esd_out_fifo with up to two results per transaction.
`default_nettype none

module esd_decoder
    import esd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_char_in,
    input  wire logic       i_string_end,
    input  wire logic       i_room,
    output t_push           o_push
);

    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_end;
    t_phase     r_phase;
    logic [7:0] r_acc;
    logic [2:0] r_cnt;

    t_phase     n_phase;
    logic [7:0] n_acc;
    logic [2:0] n_cnt;

    logic        adv;
    logic        do_plain;
    logic [4:0]  hv;
    logic [11:0] nxt;
    logic [1:0]  num;
    t_result     res_a;
    t_result     res_b;
    t_result     res_new;

    assign adv        = r_in_valid && i_room;
    assign o_in_ready = !r_in_valid || adv;
    assign hv         = hex_digit(r_char);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_char <= i_char_in;
            r_end  <= i_string_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_acc   <= 8'd0;
            r_cnt   <= 3'd0;
        end else if (adv) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        do_plain = 1'b0;
        num      = 2'd0;
        res_a    = '0;
        res_b    = '0;
        res_new  = '0;
        nxt      = 12'd0;

        unique case (r_phase)
            PH_ESC: begin
                n_phase = PH_PLAIN;
                n_acc   = 8'd0;
                n_cnt   = 3'd0;
                num     = 2'd1;
                unique case (r_char)
                    CH_LC_A:   res_a = mk_result(CODE_BEL, 1'b0);
                    CH_LC_B:   res_a = mk_result(CODE_BS, 1'b0);
                    CH_LC_R:   res_a = mk_result(CODE_CR, 1'b0);
                    CH_LC_N:   res_a = mk_result(CODE_LF, 1'b0);
                    CH_LC_T:   res_a = mk_result(CODE_HT, 1'b0);
                    CH_LC_V:   res_a = mk_result(CODE_VT, 1'b0);
                    CH_LC_F:   res_a = mk_result(CODE_FF, 1'b0);
                    CH_BSLASH,
                    CH_SQUOTE,
                    CH_DQUOTE: res_a = mk_result(r_char, 1'b0);
                    CH_LC_X,
                    CH_UC_X: begin
                        n_phase = PH_HEX;
                        num     = 2'd0;
                    end
                    CH_ZERO: begin
                        n_phase = PH_OCT;
                        num     = 2'd0;
                    end
                    default: begin
                        if (r_char >= CH_ONE && r_char <= CH_NINE) begin
                            n_phase = PH_DEC;
                            n_acc   = {4'd0, r_char[3:0]};
                            n_cnt   = 3'd1;
                            num     = 2'd0;
                        end else begin
                            res_a = mk_result(8'd0, 1'b1);
                        end
                    end
                endcase
            end
            PH_HEX: begin
                if (hv[4]) begin
                    if (r_cnt == 3'd0) begin
                        n_acc = {4'd0, hv[3:0]};
                        n_cnt = 3'd1;
                    end else begin
                        res_a   = mk_result({r_acc[3:0], hv[3:0]}, 1'b0);
                        num     = 2'd1;
                        n_phase = PH_PLAIN;
                        n_acc   = 8'd0;
                        n_cnt   = 3'd0;
                    end
                end else begin
                    res_a    = mk_result(r_acc, r_cnt == 3'd0);
                    num      = 2'd1;
                    n_phase  = PH_PLAIN;
                    n_acc    = 8'd0;
                    n_cnt    = 3'd0;
                    do_plain = 1'b1;
                end
            end
            PH_OCT, PH_DEC: begin
                if (r_phase == PH_OCT) begin
                    nxt = {1'b0, r_acc, 3'd0} + {8'd0, 1'b0, r_char[2:0]};
                end else begin
                    nxt = {1'b0, r_acc, 3'd0} + {3'd0, r_acc, 1'b0} + {8'd0, r_char[3:0]};
                end
                if (((r_phase == PH_OCT && r_char >= CH_ZERO && r_char <= CH_SEVEN) ||
                     (r_phase == PH_DEC && r_char >= CH_ZERO && r_char <= CH_NINE)) &&
                    nxt <= BYTE_MAX_VALUE) begin
                    n_acc = nxt[7:0];
                    n_cnt = r_cnt + 3'd1;
                    if ((r_phase == PH_OCT && n_cnt >= 3'd4) ||
                        (r_phase == PH_DEC && n_cnt >= 3'd3)) begin
                        res_a   = mk_result(nxt[7:0], 1'b0);
                        num     = 2'd1;
                        n_phase = PH_PLAIN;
                        n_acc   = 8'd0;
                        n_cnt   = 3'd0;
                    end
                end else begin
                    res_a    = mk_result(r_acc, 1'b0);
                    num      = 2'd1;
                    n_phase  = PH_PLAIN;
                    n_acc    = 8'd0;
                    n_cnt    = 3'd0;
                    do_plain = 1'b1;
                end
            end
            default: begin
                n_phase  = PH_PLAIN;
                n_acc    = 8'd0;
                n_cnt    = 3'd0;
                do_plain = 1'b1;
            end
        endcase

        if (do_plain) begin
            if (r_char == CH_BSLASH) begin
                n_phase = PH_ESC;
                n_acc   = 8'd0;
                n_cnt   = 3'd0;
            end else begin
                res_new = mk_result(r_char, 1'b0);
                if (num == 2'd0) begin
                    res_a = res_new;
                end else begin
                    res_b = res_new;
                end
                num = num + 2'd1;
            end
        end

        if (r_end) begin
            priority if (n_phase == PH_ESC) begin
                res_new = mk_result(8'd0, 1'b1);
            end else if (n_phase == PH_HEX) begin
                res_new = mk_result(n_acc, n_cnt == 3'd0);
            end else begin
                res_new = mk_result(n_acc, 1'b0);
            end
            if (n_phase == PH_ESC || n_phase == PH_HEX ||
                n_phase == PH_OCT || n_phase == PH_DEC) begin
                if (num == 2'd0) begin
                    res_a = res_new;
                end else begin
                    res_b = res_new;
                end
                num = num + 2'd1;
            end
            n_phase = PH_PLAIN;
            n_acc   = 8'd0;
            n_cnt   = 3'd0;
        end

        if (num == 2'd1) begin
            res_a.run_last    = 1'b1;
            res_a.string_done = r_end;
        end else if (num == 2'd2) begin
            res_b.run_last    = 1'b1;
            res_b.string_done = r_end;
        end
    end

    always_comb begin
        o_push.num   = adv ? num : 2'd0;
        o_push.res_a = res_a;
        o_push.res_b = res_b;
    end

endmodule

`default_nettype wire

// ----- design/esd_out_fifo.sv -----
// Small result queue: takes up to two results per cycle, gives one per output transaction.
// Depends on esd_pkg for the result types and queue depth.
`default_nettype none

module esd_out_fifo
    import esd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_push      i_push,
    output logic            o_room,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_result         o_result
);

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr;
    logic [FIFO_AW-1:0]   r_rd;
    logic [FIFO_CW-1:0]   r_count;
    logic                 pop;
    logic [FIFO_AW-1:0]   wr_next;

    assign o_room      = r_count <= FIFO_CW'(FIFO_DEPTH - 2);
    assign o_out_valid = r_count != '0;
    assign o_result    = r_mem[r_rd];
    assign pop         = o_out_valid && i_out_ready;
    assign wr_next     = r_wr + FIFO_AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + FIFO_AW'(i_push.num);
            r_rd    <= r_rd + FIFO_AW'(pop);
            r_count <= r_count + FIFO_CW'(i_push.num) - FIFO_CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.res_a;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_next] <= i_push.res_b;
        end
    end

endmodule

`default_nettype wire

// ----- design/escape_sequence_decoder_unit.sv -----
// Top level of the C string escape decoder: decoder stage plus result queue.
// Depends on esd_pkg, esd_decoder and esd_out_fifo.
//
// Input channel: i_in_valid / o_in_ready carry one raw character (i_char_in)
// and a last-of-string flag (i_string_end) per transaction.
// Output channel: o_out_valid / i_out_ready carry one decoded result per
// transaction: o_byte_out, o_bad_escape, o_run_last (final result of that
// character) and o_string_done (final result of the string).
// A character gives zero, one or two results.
// A result passes through the input register, then the single-pass decode
// into a four-entry result queue, from which it is offered.
// Throughput: one character per cycle while the receiver keeps up; the
// decode stage advances only when the queue has room for two results, so
// the queue depth sets how long the input keeps flowing under a stall.
// A stalled receiver fills the queue and then holds o_in_ready low; no
// result is lost or repeated.
// Reset (synchronous, active low) empties the queue, drops any held
// character and returns the parser to plain text.
`default_nettype none

module escape_sequence_decoder_unit
    import esd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_char_in,
    input  wire logic       i_string_end,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_byte_out,
    output logic            o_bad_escape,
    output logic            o_run_last,
    output logic            o_string_done
);

    t_push   push;
    logic    room;
    t_result result;

    esd_decoder u_decoder (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_char_in    (i_char_in),
        .i_string_end (i_string_end),
        .i_room       (room),
        .o_push       (push)
    );

    esd_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_byte_out    = result.byte_out;
    assign o_bad_escape  = result.bad_escape;
    assign o_run_last    = result.run_last;
    assign o_string_done = result.string_done;

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.num != 2'd0) |-> room)
        else $error("results pushed without queue room");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.num != 2'd3)
        else $error("more than two results from one transaction");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered straight after reset");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_string_done) |-> o_run_last)
        else $error("string end flagged on a non-final result");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_escape) |-> (o_byte_out == 8'd0))
        else $error("error result carries a non-zero byte");

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for escape_sequence_decoder_unit.
// Depends on esd_pkg and the design; a local decoder model predicts every result,
// directed special cases first, then random escaped strings at full rate and then with random idling.
`default_nettype none

module tb
    import esd_pkg::*;
;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 400;
    localparam int FULL_RATE_ITEMS = 100;
    localparam int IDLE_PCT = 17;
    localparam int OCT_BASE = 8;
    localparam int DEC_BASE = 10;
    localparam int MAX_HEX_DIGITS = 2;
    localparam int MAX_OCT_DIGITS = 4;
    localparam int MAX_DEC_DIGITS = 3;
    localparam int SETTLE_CYCLES = 8;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_char_in = 8'd0;
    logic       i_string_end = 1'b0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_byte_out;
    logic       o_bad_escape;
    logic       o_run_last;
    logic       o_string_done;

    logic       in_stall_on = 1'b1;
    logic       out_stall_on = 1'b1;
    int         items_sent = 0;
    int         mismatches = 0;

    // decoder model state
    t_phase     esc_phase = PH_PLAIN;
    logic [7:0] esc_value = 8'd0;
    logic [2:0] esc_digits = 3'd0;
    t_result    step_out[$];
    t_result    decoded_q[$];
    logic [7:0] text_q[$];

    escape_sequence_decoder_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_char_in     (i_char_in),
        .i_string_end  (i_string_end),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_byte_out    (o_byte_out),
        .o_bad_escape  (o_bad_escape),
        .o_run_last    (o_run_last),
        .o_string_done (o_string_done)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= !out_stall_on || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic void emit(input logic [7:0] value, input logic bad);
        t_result r;
        r.byte_out    = bad ? 8'd0 : value;
        r.bad_escape  = bad;
        r.run_last    = 1'b0;
        r.string_done = 1'b0;
        step_out.push_back(r);
    endfunction

    function automatic void to_plain();
        esc_phase  = PH_PLAIN;
        esc_value  = 8'd0;
        esc_digits = 3'd0;
    endfunction

    function automatic void close_with(input logic [7:0] value, input logic bad);
        to_plain();
        emit(value, bad);
    endfunction

    function automatic void open_escape(input t_phase ph, input logic [7:0] value,
                                        input logic [2:0] digits);
        esc_phase  = ph;
        esc_value  = value;
        esc_digits = digits;
    endfunction

    function automatic int hex_val(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_LC_A && c <= CH_LC_F) return int'(c - CH_LC_A) + 10;
        if (c >= CH_UC_A && c <= CH_UC_F) return int'(c - CH_UC_A) + 10;
        return -1;
    endfunction

    function automatic void plain_char(input logic [7:0] c);
        if (c == CH_BSLASH) open_escape(PH_ESC, 8'd0, 3'd0);
        else emit(c, 1'b0);
    endfunction

    function automatic void escape_char(input logic [7:0] c);
        case (c)
            CH_LC_A: close_with(CODE_BEL, 1'b0);
            CH_LC_B: close_with(CODE_BS, 1'b0);
            CH_LC_R: close_with(CODE_CR, 1'b0);
            CH_LC_N: close_with(CODE_LF, 1'b0);
            CH_LC_T: close_with(CODE_HT, 1'b0);
            CH_LC_V: close_with(CODE_VT, 1'b0);
            CH_LC_F: close_with(CODE_FF, 1'b0);
            CH_BSLASH, CH_SQUOTE, CH_DQUOTE: close_with(c, 1'b0);
            CH_LC_X, CH_UC_X: open_escape(PH_HEX, 8'd0, 3'd0);
            CH_ZERO: open_escape(PH_OCT, 8'd0, 3'd0);
            default: begin
                if (c >= CH_ONE && c <= CH_NINE) open_escape(PH_DEC, c - CH_ZERO, 3'd1);
                else close_with(8'd0, 1'b1);
            end
        endcase
    endfunction

    // numeric escape in octal or decimal; an ending character is handled afresh
    function automatic void digit_char(input logic [7:0] c, input logic [7:0] top_digit,
                                       input int base, input int max_digits);
        int nxt;
        if (c >= CH_ZERO && c <= top_digit)
            nxt = int'(esc_value) * base + int'(c) - int'(CH_ZERO);
        else
            nxt = int'(BYTE_MAX_VALUE) + 1;
        if (nxt <= int'(BYTE_MAX_VALUE)) begin
            esc_value  = nxt[7:0];
            esc_digits = esc_digits + 3'd1;
            if (int'(esc_digits) >= max_digits) close_with(esc_value, 1'b0);
        end else begin
            emit(esc_value, 1'b0);
            to_plain();
            plain_char(c);
        end
    endfunction

    function automatic void feed_char(input logic [7:0] c);
        int h;
        case (esc_phase)
            PH_ESC: escape_char(c);
            PH_HEX: begin
                h = hex_val(c);
                if (h >= 0) begin
                    if (esc_digits == 3'd0) begin
                        esc_value  = h[7:0];
                        esc_digits = 3'd1;
                    end else begin
                        close_with({esc_value[3:0], h[3:0]}, 1'b0);
                    end
                end else begin
                    if (esc_digits == 3'd0) emit(8'd0, 1'b1);
                    else emit(esc_value, 1'b0);
                    to_plain();
                    plain_char(c);
                end
            end
            PH_OCT: digit_char(c, CH_SEVEN, OCT_BASE, MAX_OCT_DIGITS);
            PH_DEC: digit_char(c, CH_NINE, DEC_BASE, MAX_DEC_DIGITS);
            default: begin
                to_plain();
                plain_char(c);
            end
        endcase
    endfunction

    function automatic void decode_char(input logic [7:0] c, input logic last);
        t_result r;
        step_out.delete();
        feed_char(c);
        if (last) begin
            case (esc_phase)
                PH_ESC: emit(8'd0, 1'b1);
                PH_HEX: begin
                    if (esc_digits == 3'd0) emit(8'd0, 1'b1);
                    else emit(esc_value, 1'b0);
                end
                PH_OCT, PH_DEC: emit(esc_value, 1'b0);
                default: ;
            endcase
            to_plain();
        end
        if (step_out.size() > 0) begin
            r = step_out.pop_back();
            r.run_last    = 1'b1;
            r.string_done = last;
            step_out.push_back(r);
        end
        foreach (step_out[k]) decoded_q.push_back(step_out[k]);
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0h/%0b/%0b/%0b",
                         $time, o_byte_out, o_bad_escape, o_run_last, o_string_done);
                mismatches++;
            end else begin
                want = decoded_q.pop_front();
                check_field("byte_out", want.byte_out, o_byte_out);
                check_field("bad_escape", want.bad_escape, o_bad_escape);
                check_field("run_last", want.run_last, o_run_last);
                check_field("string_done", want.string_done, o_string_done);
            end
        end
    end

    task automatic send_char(input logic [7:0] c, input logic last);
        while (in_stall_on && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_char_in    <= c;
        i_string_end <= last;
        do @(posedge i_clk); while (!o_in_ready);
        decode_char(c, last);
        items_sent++;
    endtask

    task automatic send_text(input string s, input logic last);
        for (int k = 0; k < s.len(); k++) send_char(s[k], last && (k == s.len() - 1));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [7:0] simple_letter(input int idx);
        case (idx)
            0: return CH_LC_A;
            1: return CH_LC_B;
            2: return CH_LC_R;
            3: return CH_LC_N;
            4: return CH_LC_T;
            5: return CH_LC_V;
            6: return CH_LC_F;
            7: return CH_BSLASH;
            8: return CH_SQUOTE;
            default: return CH_DQUOTE;
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input int v, input logic upper);
        if (v < 10) return CH_ZERO + v[7:0];
        return (upper ? CH_UC_A : CH_LC_A) + v[7:0] - 8'd10;
    endfunction

    task automatic add_token();
        int kind;
        kind = $urandom_range(99);
        if (kind < 22) begin
            text_q.push_back(8'($urandom_range(255)));
        end else if (kind < 38) begin
            text_q.push_back(CH_BSLASH);
            text_q.push_back(simple_letter($urandom_range(9)));
        end else if (kind < 54) begin
            text_q.push_back(CH_BSLASH);
            text_q.push_back($urandom_range(1) ? CH_UC_X : CH_LC_X);
            repeat ($urandom_range(MAX_HEX_DIGITS))
                text_q.push_back(hex_char($urandom_range(15), 1'($urandom_range(1))));
        end else if (kind < 70) begin
            text_q.push_back(CH_BSLASH);
            text_q.push_back(CH_ZERO);
            repeat ($urandom_range(MAX_OCT_DIGITS)) begin
                if ($urandom_range(9) == 0)
                    text_q.push_back(CH_SEVEN + 8'($urandom_range(1, 2)));
                else if ($urandom_range(2) == 0) text_q.push_back(CH_ZERO);
                else text_q.push_back(CH_ZERO + 8'($urandom_range(7)));
            end
        end else if (kind < 86) begin
            text_q.push_back(CH_BSLASH);
            text_q.push_back(CH_ONE + 8'($urandom_range(8)));
            repeat ($urandom_range(MAX_DEC_DIGITS - 1))
                text_q.push_back(CH_ZERO + 8'($urandom_range(9)));
        end else if (kind < 94) begin
            text_q.push_back(CH_BSLASH);
            text_q.push_back(8'($urandom_range(255)));
        end else begin
            text_q.push_back($urandom_range(1) ? CH_BSLASH : 8'($urandom_range(255)));
        end
    endtask

    // one string of random tokens; some are cut short so they may end mid-escape
    task automatic send_random_string();
        text_q.delete();
        repeat ($urandom_range(1, 8)) add_token();
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 2))
                if (text_q.size() > 1) void'(text_q.pop_back());
        end
        foreach (text_q[k]) send_char(text_q[k], k == text_q.size() - 1);
    endtask

    task automatic test_plain_extremes();
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'hA5, 1'b1);
    endtask

    task automatic test_special_cases();
        send_text("\\q", 1'b0);
        send_text("\\xg", 1'b0);
        send_text("\\0a", 1'b0);
        send_text("\\260", 1'b0);
        send_text("\\", 1'b1);
        send_text("\\x", 1'b1);
        send_text("\\x4", 1'b1);
        send_text("\\12", 1'b1);
        send_text("\\x7F", 1'b1);
    endtask

    task automatic test_full_rate();
        int stop_at;
        in_stall_on  = 1'b0;
        out_stall_on = 1'b0;
        stop_at = items_sent + FULL_RATE_ITEMS;
        while (items_sent < stop_at) send_random_string();
        in_stall_on  = 1'b1;
        out_stall_on = 1'b1;
    endtask

    task automatic test_random_strings();
        while (items_sent < ITEM_TARGET) send_random_string();
    endtask

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_plain_extremes();
        test_special_cases();
        wait_drained();
        test_full_rate();
        wait_drained();
        test_random_strings();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && decoded_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
